FILE: src/binary_heap_priority_queue_unit_defines.svh
// Assertion macros used by the heap priority queue datapath.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BHPQ_ASSERT(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
else $error("bhpq assertion failed");
`define BHPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("bhpq implication failed");
`else
`define BHPQ_ASSERT(lbl, clk, rst_n, prop)
`define BHPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/bhpq_pkg.sv
// Types, constants and helpers shared by the heap priority queue modules.
`timescale 1ns / 1ps
package bhpq_pkg;
	localparam int CAPACITY = 255;
	localparam int MAX_FILL = 255;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 8;
	localparam int DEPTH    = 256;
	localparam logic [ADDR_W-1:0] CAP_LIMIT = ADDR_W'((CAPACITY > MAX_FILL) ? MAX_FILL : CAPACITY);

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_PEEK   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SU_CHK,
		S_SU_CMP,
		S_RM_RD,
		S_RM_LD,
		S_SD_RDL,
		S_SD_RDR,
		S_SD_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic ins_start;
		logic rd_parent;
		logic rd_last;
		logic rd_left;
		logic rd_right;
		logic rm_load;
		logic ld_left;
		logic wr_val;
		logic wr_up;
		logic wr_down;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_ins;
		logic is_rem;
		logic res_ok;
		logic pos_root;
		logic val_above;
		logic no_left;
		logic move_down;
		logic out_free;
	} sts_t;

	// True when a belongs above b in the selected order.
	function automatic logic ranks_above(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b, input logic min_order);
		ranks_above = min_order ? (a < b) : (a > b);
	endfunction
endpackage

FILE: src/bhpq_ctrl.sv
// Sequencer for insert, remove and peek operations of the heap queue.
`timescale 1ns / 1ps
module bhpq_ctrl import bhpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!sts.res_ok || (!sts.is_ins && !sts.is_rem)) begin
					state_d = S_DONE;
				end else if (sts.is_ins) begin
					cmd.ins_start = 1'b1;
					state_d       = S_SU_CHK;
				end else begin
					state_d = S_RM_RD;
				end
			end
			S_SU_CHK: begin
				if (sts.pos_root) begin
					cmd.wr_val = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d       = S_SU_CMP;
				end
			end
			S_SU_CMP: begin
				if (sts.val_above) begin
					cmd.wr_up = 1'b1;
					state_d   = S_SU_CHK;
				end else begin
					cmd.wr_val = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_RM_RD: begin
				cmd.rd_last = 1'b1;
				state_d     = S_RM_LD;
			end
			S_RM_LD: begin
				cmd.rm_load = 1'b1;
				state_d     = S_SD_RDL;
			end
			S_SD_RDL: begin
				if (sts.no_left) begin
					cmd.wr_val = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.rd_left = 1'b1;
					state_d     = S_SD_RDR;
				end
			end
			S_SD_RDR: begin
				cmd.ld_left  = 1'b1;
				cmd.rd_right = 1'b1;
				state_d      = S_SD_CMP;
			end
			S_SD_CMP: begin
				if (sts.move_down) begin
					cmd.wr_down = 1'b1;
					state_d     = S_SD_RDL;
				end else begin
					cmd.wr_val = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

FILE: src/bhpq_dp.sv
// Heap store, sift registers, comparators and result register of the heap queue.
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_unit_defines.svh"
module bhpq_dp import bhpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  cmd_t        cmd,
	output sts_t        sts
);
	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [ADDR_W-1:0]        fill_q;
	logic                     order_q;
	logic                     m_tvalid_q;
	logic [47:0]              m_tdata_q;
	logic [ADDR_W-1:0]        pos_q;
	logic [1:0]               func_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] saved_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] lval_q;
	logic signed [DATA_W-1:0] rd_q;

	logic [ADDR_W:0]          left_idx;
	logic [ADDR_W:0]          right_idx;
	logic [ADDR_W-1:0]        parent_idx;
	logic                     has_right;
	logic                     l_up;
	logic                     r_up;
	logic signed [DATA_W-1:0] best_val;
	logic [ADDR_W-1:0]        raddr;
	logic [ADDR_W-1:0]        waddr;
	logic signed [DATA_W-1:0] wdata;
	logic                     we;
	logic [1:0]               in_func;
	status_t                  in_status;
	logic signed [DATA_W-1:0] res_top;

	assign in_func    = s_tdata[1:0];
	assign left_idx   = {pos_q, 1'b0};
	assign right_idx  = {pos_q, 1'b1};
	assign parent_idx = {1'b0, pos_q[ADDR_W-1:1]};
	assign has_right  = right_idx <= {1'b0, fill_q};
	assign l_up       = ranks_above(lval_q, val_q, order_q);
	assign best_val   = l_up ? lval_q : val_q;
	assign r_up       = has_right && ranks_above(rd_q, best_val, order_q);

	always_comb begin
		if (in_func == FN_INSERT) begin
			in_status = (fill_q >= CAP_LIMIT) ? ST_FULL : ST_OK;
		end else begin
			in_status = (fill_q == '0) ? ST_EMPTY : ST_OK;
		end
	end

	assign sts.is_ins    = func_q == FN_INSERT;
	assign sts.is_rem    = func_q == FN_REMOVE;
	assign sts.res_ok    = status_q == ST_OK;
	assign sts.pos_root  = pos_q == ADDR_W'(1);
	assign sts.val_above = ranks_above(val_q, rd_q, order_q);
	assign sts.no_left   = left_idx > {1'b0, fill_q};
	assign sts.move_down = l_up || r_up;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		priority if (cmd.rd_parent) begin
			raddr = parent_idx;
		end else if (cmd.rd_last) begin
			raddr = fill_q;
		end else if (cmd.rd_left) begin
			raddr = left_idx[ADDR_W-1:0];
		end else if (cmd.rd_right) begin
			raddr = right_idx[ADDR_W-1:0];
		end else begin
			raddr = '0;
		end
	end

	assign we    = cmd.wr_val || cmd.wr_up || cmd.wr_down;
	assign waddr = pos_q;

	always_comb begin
		priority if (cmd.wr_up) begin
			wdata = rd_q;
		end else if (cmd.wr_down) begin
			wdata = r_up ? rd_q : lval_q;
		end else begin
			wdata = val_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			order_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			if (cmd.ins_start) begin
				fill_q <= fill_q + ADDR_W'(1);
			end else if (cmd.rm_load) begin
				fill_q <= fill_q - ADDR_W'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (status_q == ST_EMPTY) begin
			res_top = '0;
		end else if (func_q == FN_REMOVE) begin
			res_top = saved_q;
		end else begin
			res_top = top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_func;
			val_q    <= s_tdata[33:2];
			status_q <= in_status;
			saved_q  <= top_q;
		end
		if (cmd.ins_start) begin
			pos_q <= fill_q + ADDR_W'(1);
		end else if (cmd.rm_load) begin
			pos_q <= ADDR_W'(1);
			val_q <= rd_q;
		end else if (cmd.wr_up) begin
			pos_q <= parent_idx;
		end else if (cmd.wr_down) begin
			pos_q <= r_up ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
		end
		if (cmd.ld_left) begin
			lval_q <= rd_q;
		end
		if (we && waddr == ADDR_W'(1)) begin
			top_q <= wdata;
		end
		if (cmd.out_load) begin
			m_tdata_q <= {6'd0, fill_q, res_top, status_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`BHPQ_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CAP_LIMIT)
	`BHPQ_ASSERT_IMP(a_write_not_zero, clk, arst_n, we, waddr != '0)
	`BHPQ_ASSERT_IMP(a_out_load_free, clk, arst_n, cmd.out_load, !m_tvalid_q || m_tready)
	`BHPQ_ASSERT_IMP(a_empty_result, clk, arst_n, m_tvalid_q && m_tdata_q[1:0] == ST_EMPTY, m_tdata_q[41:2] == '0)
endmodule

FILE: src/binary_heap_priority_queue_unit.sv
// A peek or a rejected operation goes from dispatch straight to the result state.
// An insert climbs one level per compare step and stops at the root or below a parent that ranks above it.
// A remove sinks one level per compare step and stops at a leaf or where no child ranks above it.
// One item is worked at a time; the unit is ready for the next transfer in the same cycle as the result appears.
// A result that is not taken holds the next operation in its final state until the transfer happens.
// The asynchronous reset empties the queue and selects the largest-on-top order.
`timescale 1ns / 1ps
module binary_heap_priority_queue_unit import bhpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // func[1:0], value[33:2], zero padding above
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[1:0], top_value[33:2], count[41:34], zero padding above
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	cmd_t cmd;
	sts_t sts;

	bhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bhpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts)
	);
endmodule
